### rtl/core/bapg_pkg.sv
// Shared constants for the battery average and percent gauge.
package bapg_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 16;
  localparam int PCT_W    = 7;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 1;

  // Default ring depth in samples.
  localparam int DEFAULT_WINDOW = 100;

  // Full scale of the percent output.
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // Width of the scaled numerator (offset times full scale).
  localparam int PCT_NUM_W = SAMPLE_W + PCT_W;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_VOLTS_MIN = 1'b0;
  localparam logic [IDX_W-1:0] REG_VOLTS_MAX = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] VOLTS_MIN_RST = 16'h0000;
  localparam logic [CFG_W-1:0] VOLTS_MAX_RST = 16'hFFFF;

endpackage

### rtl/core/bapg_ring.sv
// Sample ring with running sum, write position and fill count.
module bapg_ring #(
  parameter int WINDOW = bapg_pkg::DEFAULT_WINDOW,
  parameter int CNT_W  = $clog2(WINDOW + 1),
  parameter int SUM_W  = bapg_pkg::SAMPLE_W + CNT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bapg_pkg::SAMPLE_W-1:0] sample,
  output logic                          done,
  output logic [SUM_W-1:0]              sum,
  output logic [CNT_W-1:0]              fill
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [bapg_pkg::SAMPLE_W-1:0] mem [WINDOW];
  logic [bapg_pkg::SAMPLE_W-1:0] rd_data;
  logic [bapg_pkg::SAMPLE_W-1:0] sample_hold;
  logic [bapg_pkg::SAMPLE_W-1:0] old_val;
  logic [PTR_W-1:0]              wp;
  logic                          phase;
  logic                          full;
  logic [SUM_W-1:0]              sum_next;

  // Entries at or beyond the fill count were never written and count as zero.
  assign full     = (fill == CNT_W'(WINDOW));
  assign old_val  = full ? rd_data : '0;
  assign sum_next = sum - SUM_W'(old_val) + SUM_W'(sample_hold);

  // Ring memory: registered read of the slot about to be overwritten.
  always_ff @(posedge clk) begin
    if (start) begin
      rd_data     <= mem[wp];
      sample_hold <= sample;
    end
    if (phase) begin
      mem[wp] <= sample_hold;
    end
  end

  // Running sum, pointers and completion flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      fill  <= '0;
      wp    <= '0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      phase <= start;
      done  <= phase;
      if (phase) begin
        sum <= sum_next;
        if (!full) begin
          fill <= fill + CNT_W'(1);
        end
        if (wp == PTR_W'(WINDOW - 1)) begin
          wp <= '0;
        end else begin
          wp <= wp + PTR_W'(1);
        end
      end
    end
  end

endmodule

### rtl/core/bapg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module bapg_div #(
  parameter int N_W = 24,
  parameter int D_W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CT_W = $clog2(N_W + 1);

  logic [D_W-1:0]  rem;
  logic [D_W-1:0]  den;
  logic [CT_W-1:0] count;
  logic [D_W:0]    trial;
  logic            take;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem, quotient[N_W-1]};
  assign take  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      den      <= divisor;
      rem      <= '0;
    end else if (count != '0) begin
      quotient <= {quotient[N_W-2:0], take};
      rem      <= take ? D_W'(trial - {1'b0, den}) : trial[D_W-1:0];
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (count == CT_W'(1));
      if (start) begin
        count <= CT_W'(N_W);
      end else if (count != '0) begin
        count <= count - CT_W'(1);
      end
    end
  end

endmodule

### rtl/core/battery_average_percent_gauge.sv
// Top level of the battery average and percent gauge.
//
//   Port group | Direction | Handshake           | Payload
//   -----------+-----------+---------------------+------------------------
//   input      | in        | in_valid / in_stall | sample_mv
//   output     | out       | out_valid/out_stall | average_mv, percent
//   config     | in        | cfg_write           | cfg_index, cfg_data
//
// Each item passes through the ring, then the shared bit-serial divider runs for the
// average and, when the maximum is above the minimum, for the percent; otherwise
// the percent is zero. No new sample is taken until the item is loaded.
// Reset is synchronous; the ring needs no clearing pass since the fill
// count marks unwritten entries. A stalled result sits in the output
// register while the next item is taken and worked on.
module battery_average_percent_gauge #(
  parameter int WINDOW = bapg_pkg::DEFAULT_WINDOW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bapg_pkg::SAMPLE_W-1:0] sample_mv,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bapg_pkg::SAMPLE_W-1:0] average_mv,
  output logic [bapg_pkg::PCT_W-1:0]    percent,
  input  logic                          cfg_write,
  input  logic [bapg_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bapg_pkg::CFG_W-1:0]    cfg_data
);

  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = bapg_pkg::SAMPLE_W + CNT_W;
  localparam int DIV_N_W = (SUM_W > bapg_pkg::PCT_NUM_W) ? SUM_W : bapg_pkg::PCT_NUM_W;
  localparam int DIV_D_W = (CNT_W > bapg_pkg::SAMPLE_W) ? CNT_W : bapg_pkg::SAMPLE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RING  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIV2  = 3'd5;
  localparam logic [2:0] S_LOAD  = 3'd6;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [bapg_pkg::CFG_W-1:0]    volts_min;
  logic [bapg_pkg::CFG_W-1:0]    volts_max;
  logic                          in_take;
  logic                          ring_done;
  logic [SUM_W-1:0]              ring_sum;
  logic [CNT_W-1:0]              ring_fill;
  logic                          div_start;
  logic                          div_done;
  logic [DIV_N_W-1:0]            div_num;
  logic [DIV_D_W-1:0]            div_den;
  logic [DIV_N_W-1:0]            div_q;
  logic [bapg_pkg::SAMPLE_W-1:0] avg;
  logic [bapg_pkg::SAMPLE_W-1:0] clamped;
  logic [bapg_pkg::SAMPLE_W-1:0] span;
  logic                          span_ok;
  logic [bapg_pkg::PCT_NUM_W-1:0] scaled;
  logic                          pct_zero;
  logic                          load_ok;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign load_ok  = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      volts_min <= bapg_pkg::VOLTS_MIN_RST;
      volts_max <= bapg_pkg::VOLTS_MAX_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bapg_pkg::REG_VOLTS_MIN: volts_min <= cfg_data;
        bapg_pkg::REG_VOLTS_MAX: volts_max <= cfg_data;
        default: ;
      endcase
    end
  end

  bapg_ring #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W),
    .SUM_W  (SUM_W)
  ) u_ring (
    .clk    (clk),
    .rst    (rst),
    .start  (in_take),
    .sample (sample_mv),
    .done   (ring_done),
    .sum    (ring_sum),
    .fill   (ring_fill)
  );

  // The divider is shared: average first, then the percent.
  assign div_start = ((state == S_RING) && ring_done) || (state == S_START);
  assign div_num   = (state == S_RING) ? DIV_N_W'(ring_sum) : DIV_N_W'(scaled);
  assign div_den   = (state == S_RING) ? DIV_D_W'(ring_fill) : DIV_D_W'(span);

  bapg_div #(
    .N_W (DIV_N_W),
    .D_W (DIV_D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Clamp the average into the configured span.
  assign span_ok = (volts_max > volts_min);
  assign span    = volts_max - volts_min;
  always_comb begin
    clamped = avg;
    if (clamped > volts_max) begin
      clamped = volts_max;
    end
    if (clamped < volts_min) begin
      clamped = volts_min;
    end
  end

  // Average capture and registered scaling product.
  always_ff @(posedge clk) begin
    if ((state == S_DIV1) && div_done) begin
      avg <= div_q[bapg_pkg::SAMPLE_W-1:0];
    end
    if (state == S_SCALE) begin
      scaled   <= bapg_pkg::PCT_NUM_W'(clamped - volts_min) *
                  bapg_pkg::PCT_NUM_W'(bapg_pkg::PCT_FULL);
      pct_zero <= !span_ok;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_take) state_next = S_RING;
      S_RING:  if (ring_done) state_next = S_DIV1;
      S_DIV1:  if (div_done) state_next = S_SCALE;
      S_SCALE: state_next = span_ok ? S_START : S_LOAD;
      S_START: state_next = S_DIV2;
      S_DIV2:  if (div_done) state_next = S_LOAD;
      S_LOAD:  if (load_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register, loaded when empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_LOAD) && load_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_LOAD) && load_ok) begin
      average_mv <= avg;
      percent    <= pct_zero ? '0 : div_q[bapg_pkg::PCT_W-1:0];
    end
  end

endmodule
